/* hw/rtl/osra_pkg.sv */
`timescale 1ns / 1ps

package osra_pkg;

    localparam int SAMPLE_BITS     = 32;
    localparam int RATIO_FRAC_BITS = 16;
    localparam int RATIO_BITS      = 24;
    localparam int CALIB_SAMPLES   = 128;
    localparam int MARGIN_BITS     = 16;
    localparam int NEED_BITS       = 8;
    localparam int RUN_BITS        = 8;
    localparam int CALIB_SUM_BITS  = 31;
    localparam int CALIB_CNT_BITS  = 8;
    localparam int CFG_INDEX_BITS  = 8;
    localparam int CFG_DATA_BITS   = 16;
    localparam int QUEUE_DEPTH     = 2;

    // quotient saturates once blue >= ir << SAT_SHIFT
    localparam int SAT_SHIFT    = RATIO_BITS - RATIO_FRAC_BITS;
    localparam int MARGIN_SHIFT = MARGIN_BITS - RATIO_FRAC_BITS;
    localparam int CALIB_SHIFT  = $clog2(CALIB_SAMPLES);
    localparam int DIV_STEPS    = RATIO_BITS;
    localparam int STEP_BITS    = $clog2(DIV_STEPS);

    localparam logic [RATIO_BITS-1:0] RATIO_MAX = {RATIO_BITS{1'b1}};
    localparam logic [RUN_BITS-1:0]   RUN_MAX   = {RUN_BITS{1'b1}};

    localparam logic [MARGIN_BITS-1:0] WARNING_MARGIN_RST = 16'd2621;
    localparam logic [MARGIN_BITS-1:0] ALARM_MARGIN_RST   = 16'd3932;
    localparam logic [NEED_BITS-1:0]   CONFIRM_NEEDED_RST = 8'd1;
    localparam logic [NEED_BITS-1:0]   EXTREME_NEEDED_RST = 8'd30;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_WARNING_MARGIN = 8'd0,
        CFG_ALARM_MARGIN   = 8'd1,
        CFG_CONFIRM_NEEDED = 8'd2,
        CFG_EXTREME_NEEDED = 8'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_RECAL = 2'd0,
        KIND_ZERO  = 2'd1,
        KIND_SAT   = 2'd2,
        KIND_DIV   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [SAMPLE_BITS-1:0] blue;
        logic [SAMPLE_BITS-1:0] ir;
    } entry_t;

    typedef struct packed {
        logic [MARGIN_BITS-1:0] warning_margin;
        logic [MARGIN_BITS-1:0] alarm_margin;
        logic [NEED_BITS-1:0]   confirm_needed;
        logic [NEED_BITS-1:0]   extreme_needed;
    } cfg_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_DIV  = 2'd1,
        BK_EVAL = 2'd2
    } back_state_t;

endpackage

/* hw/rtl/optical_smoke_ratio_alarm_core.sv */
`timescale 1ns / 1ps

// Dual-wavelength smoke ratio alarm.
// Input channel (in_valid/in_ready): one request carries cmd, blue_sample and
// ir_sample. cmd = 1 restarts baseline calibration and produces no result.
// Output channel (out_valid/out_ready): one result per measurement once a
// baseline exists: ratio blue/ir in Q8.16, baseline, warning/confirmed/extreme.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index picks the
// register (0 warning margin, 1 alarm margin, 2 confirm count, 3 extreme
// count); other indexes are dropped. Write only while the block is idle.
// Path: the front register, then the two-entry queue; the back end pops the
// request, runs the bit-serial restoring divider for an ordinary ratio, then
// evaluates and loads the output register that drives out_valid. Zero or
// saturated ratios skip the divider; a recalibrate request retires when it is
// popped. The back end finishes one request before it pops the next, while the
// queue and the front register go on taking new requests.
// Reset: margins and counts return to defaults, calibration is pending, and
// the first 128 nonzero ratios build the baseline without producing results.
// Stall: a result waits in the output register; the back end holds in its
// evaluate step until that register frees, the two-entry queue and the front
// register absorb new requests, then in_ready drops.

module optical_smoke_ratio_alarm_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                cmd,
    input  logic [osra_pkg::SAMPLE_BITS-1:0]    blue_sample,
    input  logic [osra_pkg::SAMPLE_BITS-1:0]    ir_sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [osra_pkg::RATIO_BITS-1:0]     ratio_now,
    output logic [osra_pkg::RATIO_BITS-1:0]     baseline_ratio,
    output logic                                warning_flag,
    output logic                                confirmed_flag,
    output logic                                extreme_flag,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [osra_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [osra_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    osra_pkg::cfg_t   cfg_reg;
    logic             push;
    osra_pkg::entry_t push_entry;
    logic             q_full;
    logic             q_pop;
    logic             q_not_empty;
    osra_pkg::entry_t q_entry;

    // config writes go straight into the registers, so the port never stalls
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.warning_margin <= osra_pkg::WARNING_MARGIN_RST;
            cfg_reg.alarm_margin   <= osra_pkg::ALARM_MARGIN_RST;
            cfg_reg.confirm_needed <= osra_pkg::CONFIRM_NEEDED_RST;
            cfg_reg.extreme_needed <= osra_pkg::EXTREME_NEEDED_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                osra_pkg::CFG_WARNING_MARGIN:
                    cfg_reg.warning_margin <= cfg_data;
                osra_pkg::CFG_ALARM_MARGIN:
                    cfg_reg.alarm_margin <= cfg_data;
                osra_pkg::CFG_CONFIRM_NEEDED:
                    cfg_reg.confirm_needed <= cfg_data[osra_pkg::NEED_BITS-1:0];
                osra_pkg::CFG_EXTREME_NEEDED:
                    cfg_reg.extreme_needed <= cfg_data[osra_pkg::NEED_BITS-1:0];
                default:
                begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    // front: capture and classify the request
    osra_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .blue_sample (blue_sample),
        .ir_sample   (ir_sample),
        .push        (push),
        .push_entry  (push_entry),
        .q_full      (q_full)
    );

    // decouple the front from the divider
    osra_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .pop_entry  (q_entry)
    );

    // back: divide, calibrate, evaluate alarm runs, hold the result
    osra_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_not_empty    (q_not_empty),
        .q_entry        (q_entry),
        .q_pop          (q_pop),
        .cfg            (cfg_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .ratio_now      (ratio_now),
        .baseline_ratio (baseline_ratio),
        .warning_flag   (warning_flag),
        .confirmed_flag (confirmed_flag),
        .extreme_flag   (extreme_flag)
    );

endmodule

/* hw/rtl/osra_front.sv */
`timescale 1ns / 1ps

module osra_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             cmd,
    input  logic [osra_pkg::SAMPLE_BITS-1:0] blue_sample,
    input  logic [osra_pkg::SAMPLE_BITS-1:0] ir_sample,
    output logic                             push,
    output osra_pkg::entry_t                 push_entry,
    input  logic                             q_full
);

    logic             slot_valid_reg;
    osra_pkg::entry_t slot_reg;
    osra_pkg::kind_t  kind;
    logic             accept;

    // sort the request so the back end only divides when it has to
    always_comb
    begin
        if (cmd)
            kind = osra_pkg::KIND_RECAL;
        else if (ir_sample == '0)
            kind = (blue_sample != '0) ? osra_pkg::KIND_SAT : osra_pkg::KIND_ZERO;
        else if (blue_sample == '0)
            kind = osra_pkg::KIND_ZERO;
        else if ((blue_sample >> osra_pkg::SAT_SHIFT) >= ir_sample)
            kind = osra_pkg::KIND_SAT;
        else
            kind = osra_pkg::KIND_DIV;
    end

    assign push       = slot_valid_reg && !q_full;
    assign in_ready   = !slot_valid_reg || !q_full;
    assign accept     = in_valid && in_ready;
    assign push_entry = slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_valid_reg <= 1'b0;
        else if (accept)
            slot_valid_reg <= 1'b1;
        else if (push)
            slot_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg.kind <= kind;
            slot_reg.blue <= blue_sample;
            slot_reg.ir   <= ir_sample;
        end
    end

endmodule

/* hw/rtl/osra_queue.sv */
`timescale 1ns / 1ps

module osra_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  osra_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output osra_pkg::entry_t pop_entry
);

    localparam int PTR_BITS = $clog2(osra_pkg::QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(osra_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(osra_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(osra_pkg::QUEUE_DEPTH);

    osra_pkg::entry_t    mem [osra_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                do_push;
    logic                do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_entry = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

endmodule

/* hw/rtl/osra_back.sv */
`timescale 1ns / 1ps

module osra_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_not_empty,
    input  osra_pkg::entry_t                q_entry,
    output logic                            q_pop,
    input  osra_pkg::cfg_t                  cfg,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [osra_pkg::RATIO_BITS-1:0] ratio_now,
    output logic [osra_pkg::RATIO_BITS-1:0] baseline_ratio,
    output logic                            warning_flag,
    output logic                            confirmed_flag,
    output logic                            extreme_flag
);

    localparam int RB = osra_pkg::RATIO_BITS;
    localparam int SB = osra_pkg::SAMPLE_BITS;

    osra_pkg::back_state_t state_reg;
    osra_pkg::back_state_t state_next;

    logic [SB-1:0]                        ir_reg;
    logic [SB-1:0]                        rem_reg;
    logic [RB-1:0]                        dq_reg;
    logic [osra_pkg::STEP_BITS-1:0]       step_reg;
    logic [RB-1:0]                        ratio_reg;
    logic                                 calibrating_reg;
    logic [osra_pkg::CALIB_SUM_BITS-1:0]  calib_sum_reg;
    logic [osra_pkg::CALIB_CNT_BITS-1:0]  calib_count_reg;
    logic [RB-1:0]                        baseline_reg;
    logic [osra_pkg::RUN_BITS-1:0]        alarm_run_reg;
    logic [osra_pkg::RUN_BITS-1:0]        extreme_run_reg;
    logic                                 out_valid_reg;
    logic [RB-1:0]                        ratio_out_reg;
    logic [RB-1:0]                        baseline_out_reg;
    logic                                 warning_reg;
    logic                                 confirmed_reg;
    logic                                 extreme_reg;

    logic [SB:0]                          trial;
    logic [SB:0]                          diff;
    logic                                 take;
    logic [osra_pkg::CALIB_SUM_BITS-1:0]  calib_sum_next;
    logic [osra_pkg::CALIB_CNT_BITS-1:0]  calib_count_next;
    logic                                 calib_done;
    logic [RB:0]                          warn_level;
    logic [RB:0]                          alarm_level;
    logic                                 is_alarm;
    logic [osra_pkg::RUN_BITS-1:0]        alarm_run_next;
    logic [osra_pkg::RUN_BITS-1:0]        extreme_run_next;
    logic                                 out_free;
    logic                                 emit;
    logic                                 calib_step;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, dq_reg[RB-1]};
    assign take  = (trial >= {1'b0, ir_reg});
    assign diff  = trial - {1'b0, ir_reg};

    assign calib_sum_next   = calib_sum_reg + osra_pkg::CALIB_SUM_BITS'(ratio_reg);
    assign calib_count_next = calib_count_reg + 1'b1;
    assign calib_done       = (calib_count_next >=
                               osra_pkg::CALIB_CNT_BITS'(osra_pkg::CALIB_SAMPLES));

    assign warn_level  = {1'b0, baseline_reg} +
                         (RB + 1)'(cfg.warning_margin >> osra_pkg::MARGIN_SHIFT);
    assign alarm_level = {1'b0, baseline_reg} +
                         (RB + 1)'(cfg.alarm_margin >> osra_pkg::MARGIN_SHIFT);
    assign is_alarm    = ({1'b0, ratio_reg} >= alarm_level);

    assign alarm_run_next   = !is_alarm ? '0 :
                              (alarm_run_reg == osra_pkg::RUN_MAX) ? osra_pkg::RUN_MAX :
                              alarm_run_reg + 1'b1;
    assign extreme_run_next = !is_alarm ? '0 :
                              (extreme_run_reg == osra_pkg::RUN_MAX) ? osra_pkg::RUN_MAX :
                              extreme_run_reg + 1'b1;

    assign out_free   = !out_valid_reg || out_ready;
    assign emit       = (state_reg == osra_pkg::BK_EVAL) && !calibrating_reg && out_free;
    assign calib_step = (state_reg == osra_pkg::BK_EVAL) && calibrating_reg;

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            osra_pkg::BK_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop = 1'b1;
                    if (q_entry.kind == osra_pkg::KIND_DIV)
                        state_next = osra_pkg::BK_DIV;
                    else if (q_entry.kind != osra_pkg::KIND_RECAL)
                        state_next = osra_pkg::BK_EVAL;
                end
            end
            osra_pkg::BK_DIV:
            begin
                if (step_reg == '0)
                    state_next = osra_pkg::BK_EVAL;
            end
            osra_pkg::BK_EVAL:
            begin
                if (calibrating_reg || out_free)
                    state_next = osra_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = osra_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= osra_pkg::BK_IDLE;
        else
            state_reg <= state_next;
    end

    // calibration and alarm-run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calibrating_reg <= 1'b1;
            calib_sum_reg   <= '0;
            calib_count_reg <= '0;
            baseline_reg    <= '0;
            alarm_run_reg   <= '0;
            extreme_run_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (q_pop && q_entry.kind == osra_pkg::KIND_RECAL)
            begin
                calibrating_reg <= 1'b1;
                calib_sum_reg   <= '0;
                calib_count_reg <= '0;
            end
            else if (calib_step && ratio_reg != '0)
            begin
                if (calib_done)
                begin
                    baseline_reg    <= RB'(calib_sum_next >> osra_pkg::CALIB_SHIFT);
                    calibrating_reg <= 1'b0;
                    calib_sum_reg   <= '0;
                    calib_count_reg <= '0;
                end
                else
                begin
                    calib_sum_reg   <= calib_sum_next;
                    calib_count_reg <= calib_count_next;
                end
            end

            if (emit)
            begin
                alarm_run_reg   <= alarm_run_next;
                extreme_run_reg <= extreme_run_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // divider and result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            ir_reg    <= q_entry.ir;
            rem_reg   <= q_entry.blue >> osra_pkg::SAT_SHIFT;
            dq_reg    <= {q_entry.blue[osra_pkg::SAT_SHIFT-1:0],
                          {osra_pkg::RATIO_FRAC_BITS{1'b0}}};
            step_reg  <= osra_pkg::STEP_BITS'(osra_pkg::DIV_STEPS - 1);
            ratio_reg <= (q_entry.kind == osra_pkg::KIND_SAT) ? osra_pkg::RATIO_MAX : '0;
        end
        else if (state_reg == osra_pkg::BK_DIV)
        begin
            rem_reg  <= take ? diff[SB-1:0] : trial[SB-1:0];
            dq_reg   <= {dq_reg[RB-2:0], take};
            step_reg <= step_reg - 1'b1;
            if (step_reg == '0)
                ratio_reg <= {dq_reg[RB-2:0], take};
        end

        if (emit)
        begin
            ratio_out_reg    <= ratio_reg;
            baseline_out_reg <= baseline_reg;
            warning_reg      <= ({1'b0, ratio_reg} >= warn_level);
            confirmed_reg    <= is_alarm && (alarm_run_next >= cfg.confirm_needed);
            extreme_reg      <= is_alarm && (extreme_run_next >= cfg.extreme_needed);
        end
    end

    assign out_valid      = out_valid_reg;
    assign ratio_now      = ratio_out_reg;
    assign baseline_ratio = baseline_out_reg;
    assign warning_flag   = warning_reg;
    assign confirmed_flag = confirmed_reg;
    assign extreme_flag   = extreme_reg;

endmodule
